FILE: rtl/bpsc_pkg.sv
`default_nettype none

package bpsc_pkg;

    // field and datapath widths
    localparam int FIELD_W        = 32;
    localparam int COORD_BITS_DEF = 32;
    localparam int AXIS_W         = 32;
    localparam int MUL_W          = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int SHIFT_W        = 2;
    localparam int REL_W          = 2;

    // register reset values
    localparam logic [FIELD_W-1:0] BOX_RESET     = 32'd65536;
    localparam logic [FIELD_W-1:0] SEP_MIN_RESET = 32'd0;
    localparam logic [FIELD_W-1:0] SEP_MAX_RESET = 32'd65536;
    localparam logic [FIELD_W-1:0] LOS_MIN_RESET = 32'd0;
    localparam logic [FIELD_W-1:0] LOS_MAX_RESET = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_X    = 3'd0,
        CFG_BOX_Y    = 3'd1,
        CFG_BOX_Z    = 3'd2,
        CFG_SEP_MIN  = 3'd3,
        CFG_SEP_MAX  = 3'd4,
        CFG_LOS_MIN  = 3'd5,
        CFG_LOS_MAX  = 3'd6,
        CFG_BIN_MODE = 3'd7
    } cfg_reg_t;

    typedef enum logic [REL_W-1:0] {
        REL_OUTSIDE    = 2'd0,
        REL_INSIDE     = 2'd1,
        REL_CROSS      = 2'd2,
        REL_CROSS_WRAP = 2'd3
    } relation_t;

    typedef logic signed [SHIFT_W-1:0] shift_t;

    localparam shift_t SHIFT_NONE = 2'b00;
    localparam shift_t SHIFT_UP   = 2'b01;
    localparam shift_t SHIFT_DOWN = 2'b11;

    // per-item decisions handed to the classifier
    typedef struct packed {
        logic sep_min_zero;
        logic smax_gt;
        logic smin_gt;
        logic los_fail;
        logic los_ok;
        logic wrap_need;
    } bpsc_flags_t;

endpackage

`default_nettype wire

FILE: rtl/bpsc_if.sv
`default_nettype none

interface bpsc_pair_if;
    import bpsc_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] centre_a_x;
    logic [FIELD_W-1:0] centre_a_y;
    logic [FIELD_W-1:0] centre_a_z;
    logic [FIELD_W-1:0] centre_b_x;
    logic [FIELD_W-1:0] centre_b_y;
    logic [FIELD_W-1:0] centre_b_z;
    logic [FIELD_W-1:0] radius_a;
    logic [FIELD_W-1:0] radius_b;

    modport source (
        output valid, centre_a_x, centre_a_y, centre_a_z,
               centre_b_x, centre_b_y, centre_b_z, radius_a, radius_b,
        input  ready
    );

    modport sink (
        input  valid, centre_a_x, centre_a_y, centre_a_z,
               centre_b_x, centre_b_y, centre_b_z, radius_a, radius_b,
        output ready
    );
endinterface

interface bpsc_result_if;
    import bpsc_pkg::*;

    logic             valid;
    logic             ready;
    logic [REL_W-1:0] relation;
    shift_t           shift_x;
    shift_t           shift_y;
    shift_t           shift_z;

    modport source (
        output valid, relation, shift_x, shift_y, shift_z,
        input  ready
    );

    modport sink (
        input  valid, relation, shift_x, shift_y, shift_z,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/bpsc_axis_wrap.sv
`default_nettype none

module bpsc_axis_wrap #(
    parameter int CW = bpsc_pkg::COORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         en_mag,
    input  wire logic                         en_wrap,
    input  wire logic [CW-1:0]                a,
    input  wire logic [CW-1:0]                b,
    input  wire logic [bpsc_pkg::AXIS_W-1:0]  box,
    output bpsc_pkg::shift_t                  shift_reg,
    output logic [bpsc_pkg::AXIS_W-1:0]       dist_reg
);
    import bpsc_pkg::*;

    localparam int TW = ((CW + 1) > AXIS_W) ? (CW + 1) : AXIS_W;

    logic [CW:0]       diff;
    logic [CW:0]       diff_neg;
    logic [CW-1:0]     mag_next;
    logic [CW-1:0]     mag_reg;
    logic              neg_reg;
    logic [AXIS_W-1:0] mag_ext;
    logic              wrap;
    logic              mag_ge;
    logic [AXIS_W-1:0] dist_next;
    shift_t            shift_next;

    // stage one: signed offset and its magnitude
    assign diff     = {1'b0, a} - {1'b0, b};
    assign diff_neg = -diff;
    assign mag_next = diff[CW] ? diff_neg[CW-1:0] : diff[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (en_mag)
        begin
            mag_reg <= mag_next;
            neg_reg <= diff[CW];
        end
    end

    // stage two: minimum image against half a box
    assign mag_ext   = AXIS_W'(mag_reg);
    assign wrap      = TW'({mag_reg, 1'b0}) > TW'(box);
    assign mag_ge    = mag_ext >= box;
    assign dist_next = wrap ? (mag_ge ? (mag_ext - box) : (box - mag_ext)) : mag_ext;
    assign shift_next = wrap ? (neg_reg ? SHIFT_UP : SHIFT_DOWN) : SHIFT_NONE;

    always_ff @(posedge clk)
    begin
        if (en_wrap)
        begin
            dist_reg  <= dist_next;
            shift_reg <= shift_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bpsc_square.sv
`default_nettype none

module bpsc_square #(
    parameter int W = 32
) (
    input  wire logic           clk,
    input  wire logic           en,
    input  wire logic [W-1:0]   x,
    output logic [2*W-1:0]      sq_reg
);
    import bpsc_pkg::*;

    logic [2*W-1:0] sq_next;

    generate
        if (W <= MUL_W)
        begin : g_direct
            assign sq_next = x * x;
        end
        else
        begin : g_split
            // split off the top bits so the multiplier stays 32 by 32
            localparam int HW = W - MUL_W;

            logic [MUL_W-1:0]   xl;
            logic [HW-1:0]      xh;
            logic [2*MUL_W-1:0] p_ll;
            logic [W-1:0]       p_hl;
            logic [2*HW-1:0]    p_hh;

            assign xl   = x[MUL_W-1:0];
            assign xh   = x[W-1:MUL_W];
            assign p_ll = xl * xl;
            assign p_hl = xh * xl;
            assign p_hh = xh * xh;
            assign sq_next = (2*W)'(p_ll)
                           + ((2*W)'(p_hl) << (MUL_W + 1))
                           + ((2*W)'(p_hh) << (2 * MUL_W));
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bpsc_classify.sv
`default_nettype none

module bpsc_classify #(
    parameter int BW = 34
) (
    input  wire logic [2*bpsc_pkg::AXIS_W+1:0]  sum,
    input  wire logic [2*BW-1:0]                sq_max_outer,
    input  wire logic [2*bpsc_pkg::AXIS_W-1:0]  sq_max_inner,
    input  wire logic [2*bpsc_pkg::AXIS_W-1:0]  sq_min_inner,
    input  wire logic [2*BW-1:0]                sq_min_outer,
    input  wire bpsc_pkg::bpsc_flags_t          flags,
    output bpsc_pkg::relation_t                 relation
);
    import bpsc_pkg::*;

    logic [2*BW-1:0] sum_ext;
    logic            lt_max_outer;
    logic            lt_max_inner;
    logic            lt_min_inner;
    logic            lt_min_outer;
    logic            is_outside;
    logic            is_inside;

    assign sum_ext      = (2*BW)'(sum);
    assign lt_max_outer = sum_ext < sq_max_outer;
    assign lt_max_inner = sum_ext < (2*BW)'(sq_max_inner);
    assign lt_min_inner = sum_ext < (2*BW)'(sq_min_inner);
    assign lt_min_outer = sum_ext < sq_min_outer;

    assign is_outside = !lt_max_outer || flags.los_fail
                      || (!flags.sep_min_zero && flags.smin_gt && lt_min_inner);
    assign is_inside  = flags.smax_gt && lt_max_inner && flags.los_ok
                      && (flags.sep_min_zero || !lt_min_outer);

    always_comb
    begin
        if (is_outside)
        begin
            relation = REL_OUTSIDE;
        end
        else if (is_inside)
        begin
            relation = REL_INSIDE;
        end
        else if (flags.wrap_need)
        begin
            relation = REL_CROSS_WRAP;
        end
        else
        begin
            relation = REL_CROSS;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ball_pair_separation_classifier_unit.sv
// pipeline: five register stages, from the input stage through to the output register
// throughput: one item per cycle unless the output stalls; five stages with per-stage valids
// a stalled output only holds the stages that are full; empty stages keep filling
// reset (rst_n low, asynchronous) empties the pipeline and loads the default box,
// separation range and isotropic mode
`default_nettype none

module ball_pair_separation_classifier_unit #(
    parameter int COORD_BITS = bpsc_pkg::COORD_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bpsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bpsc_pkg::FIELD_W-1:0]    cfg_data,
    bpsc_pair_if.sink                            pair,
    bpsc_result_if.source                        result
);
    import bpsc_pkg::*;

    // coordinates beyond the port width are simply the whole field
    localparam int CW   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    // radius sum
    localparam int SW   = CW + 1;
    // bound plus radius sum
    localparam int BW   = ((SW > AXIS_W) ? SW : AXIS_W) + 1;
    // sum of three squared offsets
    localparam int SUMW = 2 * AXIS_W + 2;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0] box_x_reg;
    logic [FIELD_W-1:0] box_y_reg;
    logic [FIELD_W-1:0] box_z_reg;
    logic [FIELD_W-1:0] sep_min_reg;
    logic [FIELD_W-1:0] sep_max_reg;
    logic [FIELD_W-1:0] los_min_reg;
    logic [FIELD_W-1:0] los_max_reg;
    logic               bin_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_x_reg    <= BOX_RESET;
            box_y_reg    <= BOX_RESET;
            box_z_reg    <= BOX_RESET;
            sep_min_reg  <= SEP_MIN_RESET;
            sep_max_reg  <= SEP_MAX_RESET;
            los_min_reg  <= LOS_MIN_RESET;
            los_max_reg  <= LOS_MAX_RESET;
            bin_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BOX_X:    box_x_reg    <= cfg_data;
                CFG_BOX_Y:    box_y_reg    <= cfg_data;
                CFG_BOX_Z:    box_z_reg    <= cfg_data;
                CFG_SEP_MIN:  sep_min_reg  <= cfg_data;
                CFG_SEP_MAX:  sep_max_reg  <= cfg_data;
                CFG_LOS_MIN:  los_min_reg  <= cfg_data;
                CFG_LOS_MAX:  los_max_reg  <= cfg_data;
                CFG_BIN_MODE: bin_mode_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: each stage moves when it is empty or the next one
    // moves, so bubbles close up behind a stalled output
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || result.ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign pair.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= pair.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stages one and two: per-axis minimum image (offset, then wrap)
    // ------------------------------------------------------------------
    logic [AXIS_W-1:0] ax2, ay2, az2;
    shift_t            shx2, shy2, shz2;

    bpsc_axis_wrap #(.CW(CW)) u_wrap_x (
        .clk       (clk),
        .en_mag    (en1),
        .en_wrap   (en2),
        .a         (pair.centre_a_x[CW-1:0]),
        .b         (pair.centre_b_x[CW-1:0]),
        .box       (box_x_reg),
        .shift_reg (shx2),
        .dist_reg  (ax2)
    );

    bpsc_axis_wrap #(.CW(CW)) u_wrap_y (
        .clk       (clk),
        .en_mag    (en1),
        .en_wrap   (en2),
        .a         (pair.centre_a_y[CW-1:0]),
        .b         (pair.centre_b_y[CW-1:0]),
        .box       (box_y_reg),
        .shift_reg (shy2),
        .dist_reg  (ay2)
    );

    bpsc_axis_wrap #(.CW(CW)) u_wrap_z (
        .clk       (clk),
        .en_mag    (en1),
        .en_wrap   (en2),
        .a         (pair.centre_a_z[CW-1:0]),
        .b         (pair.centre_b_z[CW-1:0]),
        .box       (box_z_reg),
        .shift_reg (shz2),
        .dist_reg  (az2)
    );

    // radius sum in stage one
    logic [SW-1:0] sr1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sr1_reg <= SW'(pair.radius_a[CW-1:0]) + SW'(pair.radius_b[CW-1:0]);
        end
    end

    // stage two: separation and line-of-sight bounds widened by the radius sum
    logic [BW-1:0]     sr1_w;
    logic [BW-1:0]     sep_max_w;
    logic [BW-1:0]     sep_min_w;
    logic [BW-1:0]     max_diff;
    logic [BW-1:0]     min_diff;

    logic [SW-1:0]     sr2_reg;
    logic [BW-1:0]     max_outer2_reg;
    logic [AXIS_W-1:0] max_inner2_reg;
    logic [AXIS_W-1:0] min_inner2_reg;
    logic [BW-1:0]     min_outer2_reg;
    logic              smax_gt2_reg;
    logic              smin_gt2_reg;
    logic [BW-1:0]     los_max_sr2_reg;
    logic [BW-1:0]     los_min_sr2_reg;

    assign sr1_w     = BW'(sr1_reg);
    assign sep_max_w = BW'(sep_max_reg);
    assign sep_min_w = BW'(sep_min_reg);
    // only used when the bound exceeds the radius sum, so it fits the axis width
    assign max_diff  = sep_max_w - sr1_w;
    assign min_diff  = sep_min_w - sr1_w;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            sr2_reg         <= sr1_reg;
            max_outer2_reg  <= sep_max_w + sr1_w;
            max_inner2_reg  <= max_diff[AXIS_W-1:0];
            min_inner2_reg  <= min_diff[AXIS_W-1:0];
            min_outer2_reg  <= sep_min_w + sr1_w;
            smax_gt2_reg    <= sep_max_w > sr1_w;
            smin_gt2_reg    <= sep_min_w > sr1_w;
            los_max_sr2_reg <= BW'(los_max_reg) + sr1_w;
            los_min_sr2_reg <= BW'(los_min_reg) + sr1_w;
        end
    end

    // ------------------------------------------------------------------
    // stage three: squares, line-of-sight band and wrap-check decisions
    // ------------------------------------------------------------------
    logic [2*AXIS_W-1:0] sq_ax3, sq_ay3, sq_az3;
    logic [2*BW-1:0]     sq_max_outer3, sq_min_outer3;
    logic [2*AXIS_W-1:0] sq_max_inner3, sq_min_inner3;

    bpsc_square #(.W(AXIS_W)) u_sq_ax (
        .clk (clk), .en (en3), .x (ax2), .sq_reg (sq_ax3)
    );
    bpsc_square #(.W(AXIS_W)) u_sq_ay (
        .clk (clk), .en (en3), .x (ay2), .sq_reg (sq_ay3)
    );
    bpsc_square #(.W(AXIS_W)) u_sq_az (
        .clk (clk), .en (en3), .x (az2), .sq_reg (sq_az3)
    );
    bpsc_square #(.W(BW)) u_sq_max_outer (
        .clk (clk), .en (en3), .x (max_outer2_reg), .sq_reg (sq_max_outer3)
    );
    bpsc_square #(.W(AXIS_W)) u_sq_max_inner (
        .clk (clk), .en (en3), .x (max_inner2_reg), .sq_reg (sq_max_inner3)
    );
    bpsc_square #(.W(AXIS_W)) u_sq_min_inner (
        .clk (clk), .en (en3), .x (min_inner2_reg), .sq_reg (sq_min_inner3)
    );
    bpsc_square #(.W(BW)) u_sq_min_outer (
        .clk (clk), .en (en3), .x (min_outer2_reg), .sq_reg (sq_min_outer3)
    );

    logic [BW-1:0] sr2_w;
    logic [BW-1:0] az_w;
    logic [BW-1:0] zmax;
    logic [BW-1:0] reach_x, reach_y, reach_z;
    logic          los_min_zero;
    bpsc_flags_t   flags_next;
    bpsc_flags_t   flags3_reg;
    shift_t        shx3_reg, shy3_reg, shz3_reg;

    assign sr2_w        = BW'(sr2_reg);
    assign az_w         = BW'(az2);
    assign zmax         = az_w + sr2_w;
    assign reach_x      = BW'(ax2) + sr2_w;
    assign reach_y      = BW'(ay2) + sr2_w;
    assign reach_z      = az_w + sr2_w;
    assign los_min_zero = los_min_reg == '0;

    always_comb
    begin
        flags_next.sep_min_zero = sep_min_reg == '0;
        flags_next.smax_gt      = smax_gt2_reg;
        flags_next.smin_gt      = smin_gt2_reg;
        // line-of-sight band only applies in perpendicular mode
        flags_next.los_fail     = bin_mode_reg
                                && ((az_w >= los_max_sr2_reg)
                                    || (!los_min_zero && (zmax < BW'(los_min_reg))));
        flags_next.los_ok       = !bin_mode_reg
                                || ((zmax < BW'(los_max_reg))
                                    && (los_min_zero || (az_w >= los_min_sr2_reg)));
        // the pair may reach past half a box on some axis
        flags_next.wrap_need    = ({reach_x, 1'b0} >= (BW+1)'(box_x_reg))
                                || ({reach_y, 1'b0} >= (BW+1)'(box_y_reg))
                                || ({reach_z, 1'b0} >= (BW+1)'(box_z_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            flags3_reg <= flags_next;
            shx3_reg   <= shx2;
            shy3_reg   <= shy2;
            shz3_reg   <= shz2;
        end
    end

    // ------------------------------------------------------------------
    // stage four: squared separation (z dropped in perpendicular mode)
    // ------------------------------------------------------------------
    logic [SUMW-1:0]     sum4_reg;
    logic [2*BW-1:0]     sq_max_outer4_reg, sq_min_outer4_reg;
    logic [2*AXIS_W-1:0] sq_max_inner4_reg, sq_min_inner4_reg;
    bpsc_flags_t         flags4_reg;
    shift_t              shx4_reg, shy4_reg, shz4_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            sum4_reg          <= SUMW'(sq_ax3) + SUMW'(sq_ay3)
                               + (bin_mode_reg ? {SUMW{1'b0}} : SUMW'(sq_az3));
            sq_max_outer4_reg <= sq_max_outer3;
            sq_max_inner4_reg <= sq_max_inner3;
            sq_min_inner4_reg <= sq_min_inner3;
            sq_min_outer4_reg <= sq_min_outer3;
            flags4_reg        <= flags3_reg;
            shx4_reg          <= shx3_reg;
            shy4_reg          <= shy3_reg;
            shz4_reg          <= shz3_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage five: classification into the output register
    // ------------------------------------------------------------------
    relation_t rel_next;
    relation_t relation_reg;
    shift_t    shx5_reg, shy5_reg, shz5_reg;

    bpsc_classify #(.BW(BW)) u_classify (
        .sum          (sum4_reg),
        .sq_max_outer (sq_max_outer4_reg),
        .sq_max_inner (sq_max_inner4_reg),
        .sq_min_inner (sq_min_inner4_reg),
        .sq_min_outer (sq_min_outer4_reg),
        .flags        (flags4_reg),
        .relation     (rel_next)
    );

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            relation_reg <= rel_next;
            shx5_reg     <= shx4_reg;
            shy5_reg     <= shy4_reg;
            shz5_reg     <= shz4_reg;
        end
    end

    assign result.valid    = v5_reg;
    assign result.relation = relation_reg;
    assign result.shift_x  = shx5_reg;
    assign result.shift_y  = shy5_reg;
    assign result.shift_z  = shz5_reg;

endmodule

`default_nettype wire
